FILE: src/rur_pkg.sv
// Shared types, constants and helper functions for the reliable UDP receiver.
// No dependencies; every other file in src imports this package.
package rur_pkg;

  // Payload size that commit lengths saturate at, and the commit count width
  localparam int PAYLOAD_BYTES = 2048;
  localparam int COMMIT_W      = 12;

  // Word position bookkeeping
  localparam int INDEX_W   = 11;
  localparam int INDEX_MAX = (1 << INDEX_W) - 1;
  localparam int CSUM_IDX  = 6;

  // Result queue depth (one FIN/CLOSE packet pushes two results)
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_SERVER_SEQ = 1'b0;  // register index, paddr[2]
  localparam logic [31:0] SERVER_SEQ_RESET = 32'd1;

  // Header flag bits
  localparam logic [15:0] FLAG_SYN      = 16'h0001;
  localparam logic [15:0] FLAG_ACK      = 16'h0002;
  localparam logic [15:0] FLAG_FIN      = 16'h0004;
  localparam logic [15:0] FLAG_DATA     = 16'h0008;
  localparam logic [15:0] FLAG_FILENAME = 16'h0010;
  localparam logic [15:0] FLAG_CLOSE    = 16'h0020;

  // Commit kinds
  localparam logic [1:0] COMMIT_NONE = 2'd0;
  localparam logic [1:0] COMMIT_NAME = 2'd1;
  localparam logic [1:0] COMMIT_DATA = 2'd2;

  typedef enum logic [3:0] {
    ST_BAD_CSUM  = 4'd0,
    ST_IGNORED   = 4'd1,
    ST_SYN       = 4'd2,
    ST_HS_DONE   = 4'd3,
    ST_NAME      = 4'd4,
    ST_DATA      = 4'd5,
    ST_OUT_ORDER = 4'd6,
    ST_NO_FILE   = 4'd7,
    ST_FIN       = 4'd8,
    ST_CLOSE     = 4'd9,
    ST_EXTRA_ACK = 4'd10
  } status_t;

  typedef enum logic [1:0] {
    PH_HANDSHAKE   = 2'd0,
    PH_ESTABLISHED = 2'd1,
    PH_CLOSED      = 2'd2
  } phase_t;

  // Input word
  typedef struct packed {
    logic [15:0] packet_word;
    logic        packet_end;
  } rx_item_t;

  // Result word
  typedef struct packed {
    logic                send_frame;
    logic [31:0]         reply_seq;
    logic [31:0]         reply_ack;
    logic [5:0]          reply_flags;
    logic [15:0]         reply_checksum;
    logic [1:0]          commit_kind;
    logic [COMMIT_W-1:0] commit_bytes;
    logic [3:0]          status;
    logic                run_last;
  } res_item_t;

  // Parsed packet view handed from the parser to the session logic
  typedef struct packed {
    logic        good;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] flags;
    logic [15:0] length;
  } pkt_info_t;

  // Ones' complement add with end-around carry
  function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  // Checksum over a reply header (length, checksum and payload are zero)
  function automatic logic [15:0] frame_checksum(logic [31:0] seq, logic [31:0] ack,
                                                 logic [5:0] flags);
    logic [15:0] s;
    s = oc_add(seq[15:0], seq[31:16]);
    s = oc_add(s, ack[15:0]);
    s = oc_add(s, ack[31:16]);
    s = oc_add(s, {10'd0, flags});
    return ~s;
  endfunction

  // Result carrying a frame; commit and status fields left zero
  function automatic res_item_t make_frame(logic [31:0] seq, logic [31:0] ack,
                                           logic [5:0] flags);
    res_item_t r;
    r = '0;
    r.send_frame     = 1'b1;
    r.reply_seq      = seq;
    r.reply_ack      = ack;
    r.reply_flags    = flags;
    r.reply_checksum = frame_checksum(seq, ack, flags);
    return r;
  endfunction

endpackage

FILE: src/rur_parse.sv
// Packet parser: word position, header capture and running ones' complement sum.
// Depends on rur_pkg.
module rur_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  rur_pkg::rx_item_t   item,
  output rur_pkg::pkt_info_t  pkt
);
  import rur_pkg::*;

  logic [INDEX_W-1:0] word_index;
  logic [15:0]        word_sum;
  logic [31:0]        header_seq;
  logic [31:0]        header_ack;
  logic [15:0]        header_flags;
  logic [15:0]        header_length;
  logic [15:0]        header_checksum;

  logic [15:0] word_sum_next;
  logic [31:0] header_seq_next;
  logic [31:0] header_ack_next;
  logic [15:0] header_flags_next;
  logic [15:0] header_length_next;
  logic [15:0] header_checksum_next;
  logic [15:0] w;

  assign w = item.packet_word;

  // Capture header words by position; sum every word but the checksum
  always_comb begin
    header_seq_next      = header_seq;
    header_ack_next      = header_ack;
    header_flags_next    = header_flags;
    header_length_next   = header_length;
    header_checksum_next = header_checksum;
    unique case (word_index)
      INDEX_W'(0): header_seq_next[15:0]  = w;
      INDEX_W'(1): header_seq_next[31:16] = w;
      INDEX_W'(2): header_ack_next[15:0]  = w;
      INDEX_W'(3): header_ack_next[31:16] = w;
      INDEX_W'(4): header_flags_next      = w;
      INDEX_W'(5): header_length_next     = w;
      INDEX_W'(CSUM_IDX): header_checksum_next = w;
      default: ;
    endcase
    word_sum_next = (word_index == INDEX_W'(CSUM_IDX)) ? word_sum : oc_add(word_sum, w);
  end

  // Packet view as of the current word
  always_comb begin
    pkt.good   = (word_index >= INDEX_W'(CSUM_IDX)) &&
                 (~word_sum_next == header_checksum_next);
    pkt.seq    = header_seq_next;
    pkt.ack    = header_ack_next;
    pkt.flags  = header_flags_next;
    pkt.length = header_length_next;
  end

  // Control state: position and sum restart after the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= '0;
      word_sum   <= '0;
    end else if (advance) begin
      if (item.packet_end) begin
        word_index <= '0;
        word_sum   <= '0;
      end else begin
        word_sum <= word_sum_next;
        if (word_index != INDEX_W'(INDEX_MAX)) begin
          word_index <= word_index + INDEX_W'(1);
        end
      end
    end
  end

  // Header fields
  always_ff @(posedge clk) begin
    if (advance) begin
      header_seq      <= header_seq_next;
      header_ack      <= header_ack_next;
      header_flags    <= header_flags_next;
      header_length   <= header_length_next;
      header_checksum <= header_checksum_next;
    end
  end

endmodule

FILE: src/rur_session.sv
// Session state machine: handshake, sequence-checked transfer and teardown.
// Builds one or two result words per packet. Depends on rur_pkg.
module rur_session (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  rur_pkg::pkt_info_t  pkt,
  input  logic [31:0]         server_seq,
  output rur_pkg::res_item_t  res0,
  output rur_pkg::res_item_t  res1,
  output logic                two
);
  import rur_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] expected_seq, expected_seq_next;
  logic        file_open, file_open_next;

  logic                is_xfer;
  logic                is_name;
  logic                is_teardown;
  logic                in_order;
  logic [31:0]         seq_plus;
  logic [COMMIT_W-1:0] bytes;

  // Shared decode
  always_comb begin
    is_xfer     = (pkt.flags & (FLAG_FILENAME | FLAG_DATA)) != '0;
    is_name     = (pkt.flags & FLAG_FILENAME) != '0;
    is_teardown = (pkt.flags & (FLAG_FIN | FLAG_CLOSE)) != '0;
    in_order    = pkt.seq == expected_seq;
    seq_plus    = pkt.seq + 32'd1;
    bytes       = (pkt.length > 16'(PAYLOAD_BYTES)) ? COMMIT_W'(PAYLOAD_BYTES)
                                                    : pkt.length[COMMIT_W-1:0];
  end

  // Next state
  always_comb begin
    phase_next        = phase;
    expected_seq_next = expected_seq;
    file_open_next    = file_open;
    if (fire && pkt.good) begin
      unique case (phase)
        PH_HANDSHAKE: begin
          if ((pkt.flags & FLAG_SYN) == '0 && (pkt.flags & FLAG_ACK) != '0) begin
            expected_seq_next = pkt.ack;
            phase_next        = PH_ESTABLISHED;
          end
        end
        PH_ESTABLISHED: begin
          priority if (is_xfer) begin
            if (in_order && (is_name || file_open)) begin
              file_open_next    = file_open | is_name;
              expected_seq_next = expected_seq + 32'd1;
            end
          end else if (is_teardown) begin
            file_open_next = 1'b0;
            phase_next     = PH_CLOSED;
          end else begin
          end
        end
        default: ;
      endcase
    end
  end

  // Result words
  always_comb begin
    res0 = '0;
    res1 = '0;
    two  = 1'b0;
    res0.status = ST_BAD_CSUM;
    if (pkt.good) begin
      res0.status = ST_IGNORED;
      unique case (phase)
        PH_HANDSHAKE: begin
          priority if ((pkt.flags & FLAG_SYN) != '0) begin
            res0 = make_frame(server_seq, seq_plus, 6'(FLAG_SYN | FLAG_ACK));
            res0.status = ST_SYN;
          end else if ((pkt.flags & FLAG_ACK) != '0) begin
            res0.status = ST_HS_DONE;
          end else begin
          end
        end
        PH_ESTABLISHED: begin
          priority if (is_xfer) begin
            priority if (!in_order) begin
              res0 = make_frame(32'd0, expected_seq, 6'(FLAG_ACK));
              res0.status = ST_OUT_ORDER;
            end else if (!is_name && !file_open) begin
              res0.status = ST_NO_FILE;
            end else begin
              res0 = make_frame(32'd0, seq_plus, 6'(FLAG_ACK));
              res0.commit_kind  = is_name ? COMMIT_NAME : COMMIT_DATA;
              res0.commit_bytes = bytes;
              res0.status       = is_name ? ST_NAME : ST_DATA;
            end
          end else if (is_teardown) begin
            // ACK the peer, then send our own FIN
            res0 = make_frame(32'd0, seq_plus, 6'(FLAG_ACK));
            res1 = make_frame(32'd0, 32'd0, 6'(FLAG_FIN));
            res0.status = ((pkt.flags & FLAG_FIN) != '0) ? ST_FIN : ST_CLOSE;
            res1.status = res0.status;
            two = 1'b1;
          end else if ((pkt.flags & FLAG_ACK) != '0) begin
            res0.status = ST_EXTRA_ACK;
          end else begin
          end
        end
        default: ;
      endcase
    end
    res0.run_last = !two;
    res1.run_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HANDSHAKE;
      expected_seq <= '0;
      file_open    <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      expected_seq <= expected_seq_next;
      file_open    <= file_open_next;
    end
  end

endmodule

FILE: src/rur_res_queue.sv
// Result queue: takes zero, one or two result words a cycle, gives one.
// Depends on rur_pkg.
module rur_res_queue (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push_one,
  input  logic                             push_two,
  input  rur_pkg::res_item_t               in0,
  input  rur_pkg::res_item_t               in1,
  input  logic                             pop,
  output rur_pkg::res_item_t               head,
  output logic                             valid,
  output logic [rur_pkg::Q_CNT_W-1:0]      count
);
  import rur_pkg::*;

  res_item_t          mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_PTR_W-1:0] wr_ptr_plus;
  logic               do_pop;
  logic [Q_CNT_W-1:0] push_cnt;

  assign wr_ptr_plus = wr_ptr + Q_PTR_W'(1);
  assign valid       = count != '0;
  assign head        = mem[rd_ptr];
  assign do_pop      = pop && valid;
  assign push_cnt    = push_two ? Q_CNT_W'(2) : (push_one ? Q_CNT_W'(1) : Q_CNT_W'(0));

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push_one || push_two) begin
      mem[wr_ptr] <= in0;
    end
    if (push_two) begin
      mem[wr_ptr_plus] <= in1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt[Q_PTR_W-1:0];
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      count <= count + push_cnt - (do_pop ? Q_CNT_W'(1) : Q_CNT_W'(0));
    end
  end

endmodule

FILE: src/reliable_udp_receiver_unit.sv
// Top level of the reliable UDP receiver: input register, parser, session, queue.
// Depends on rur_pkg, rur_parse, rur_session and rur_res_queue.
//
// Packet words enter one per cycle into an input register; the parser sums and
// captures the header as each word leaves that register, and on the last word the
// session logic decides the reply and pushes one result word (two for FIN or
// CLOSE once established: an ACK frame then a FIN frame) into a four-entry result
// queue. A non-final word always moves on in the next cycle; a final word waits
// in the input register while the queue has fewer than two free entries, so the
// input sustains one word per cycle as long as results are drained. Result words
// enter the queue as the last word leaves the input register and are offered once
// earlier results have left; queued words leave one per cycle while res_stall is
// low. The server_initial_seq register sits at byte address 0; the user must write
// it only while the block is idle, and the block itself does not enforce this.
module reliable_udp_receiver_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              rx_valid,
  output logic                              rx_stall,
  input  rur_pkg::rx_item_t                 rx_item,
  output logic                              res_valid,
  input  logic                              res_stall,
  output rur_pkg::res_item_t                res_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rur_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [rur_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [rur_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import rur_pkg::*;

  logic [31:0]        server_initial_seq;
  logic               in_full;
  rx_item_t           in_q;
  logic               proceed;
  logic               room2;
  logic               load;
  logic               fire;
  pkt_info_t          pkt;
  res_item_t          res0, res1;
  logic               two;
  logic [Q_CNT_W-1:0] q_count;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SERVER_SEQ) ? server_initial_seq : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_initial_seq <= SERVER_SEQ_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_SERVER_SEQ) begin
      server_initial_seq <= pwdata;
    end
  end

  // Input register: hold a last word until the queue can take two results
  assign room2    = q_count <= Q_CNT_W'(Q_DEPTH - 2);
  assign proceed  = in_full && (!in_q.packet_end || room2);
  assign rx_stall = in_full && !proceed;
  assign load     = rx_valid && !rx_stall;
  assign fire     = proceed && in_q.packet_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (load) begin
      in_full <= 1'b1;
    end else if (proceed) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_q <= rx_item;
    end
  end

  rur_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (proceed),
    .item    (in_q),
    .pkt     (pkt)
  );

  rur_session u_session (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .pkt        (pkt),
    .server_seq (server_initial_seq),
    .res0       (res0),
    .res1       (res1),
    .two        (two)
  );

  rur_res_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_one (fire && !two),
    .push_two (fire && two),
    .in0      (res0),
    .in1      (res1),
    .pop      (!res_stall),
    .head     (res_item),
    .valid    (res_valid),
    .count    (q_count)
  );

`ifndef SYNTHESIS
  // Queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue count beyond depth");

  // A teardown pair carries one status and marks only the second word last
  a_pair_shape: assert property (@(posedge clk) disable iff (rst)
    fire && two |-> res0.status == res1.status && !res0.run_last && res1.run_last)
    else $error("teardown result pair malformed");

  // Only the first word of a pair may be non-final, and it is always a frame
  a_nonlast_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.run_last |-> res_item.send_frame)
    else $error("non-final result without a frame");

  // A word that waits in the input register has just been refused room
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> in_q.packet_end && q_count > Q_CNT_W'(Q_DEPTH - 2))
    else $error("input stalled without a full queue");
`endif

endmodule
